// ----- src/ttw_pkg.sv -----
package ttw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CELL_W = 16;

  // result field widths
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;
  localparam int OUT_POS_W = 11;

  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam logic [7:0] BLANK_CHAR  = 8'h20;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MOVE  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

endpackage

// ----- src/ttw_if.sv -----
interface ttw_cmd_if;
  import ttw_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_code;
  logic [7:0] row_arg;
  logic [7:0] col_arg;

  modport source (output valid, operation, char_code, row_arg, col_arg, input ready);
  modport sink   (input valid, operation, char_code, row_arg, col_arg, output ready);
endinterface

interface ttw_rsp_if;
  import ttw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUT_ROW_W-1:0] cursor_row;
  logic [OUT_COL_W-1:0] cursor_col;
  logic [OUT_POS_W-1:0] cursor_position;
  logic [CELL_W-1:0]    cell_data;

  modport source (output valid, cursor_row, cursor_col, cursor_position, cell_data,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, cursor_position, cell_data,
                  output ready);
endinterface

// ----- src/text_terminal_writer_core.sv -----
// channel  | dir | handshake             | payload
// cmd_i    | in  | valid/ready           | operation, char_code, row_arg, col_arg
// rsp_o    | out | valid/ready           | cursor_row, cursor_col, cursor_position, cell_data
// cfg      | in  | cfg_we_i, no wait     | cfg_wdata_i (text color)
//
// one command at a time; a read has an extra step (ST_READ) to wait for the
// registered screen memory data
// a line feed or wrap on the last row scrolls: one memory copy per cycle,
// then the bottom row is filled with blanks, all through the single write port
// after reset a clearing pass fills the screen with blanks; cmd_i is not ready
// meanwhile, color writes are taken
// a result waiting on rsp_o holds the block in its finish step until taken
module text_terminal_writer_core import ttw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttw_cmd_if.sink    cmd_i,
  ttw_rsp_if.source  rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [7:0]         color_q;
  logic               pend_q, pend_d;
  logic [ADDR_W-1:0]  waddr_q, waddr_d;
  logic [CELL_W-1:0]  cell_q, cell_d;
  logic               out_vld_q, out_vld_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;
  logic [OUT_COL_W-1:0] out_col_q, out_col_d;
  logic [OUT_POS_W-1:0] out_pos_q, out_pos_d;
  logic [CELL_W-1:0]    out_cell_q, out_cell_d;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic              accept;
  logic              row_last, col_last;
  logic [ROW_W-1:0]  arg_row;
  logic [COL_W-1:0]  arg_col;
  logic [ADDR_W-1:0] cur_addr, arg_addr, cur_pos;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign row_last = (row_q == ROW_W'(ROWS - 1));
  assign col_last = (col_q == COL_W'(COLUMNS - 1));

  // clamp arguments to the screen
  assign arg_row = (cmd_i.row_arg > 8'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(cmd_i.row_arg);
  assign arg_col = (cmd_i.col_arg > 8'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                     : COL_W'(cmd_i.col_arg);

  assign cur_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign arg_addr = ADDR_W'(arg_row) * ADDR_W'(COLUMNS) + ADDR_W'(arg_col);
  assign cur_pos  = cur_addr;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    pend_d     = 1'b0;
    waddr_d    = waddr_q;
    cell_d     = cell_q;
    out_vld_d  = out_vld_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_pos_d  = out_pos_q;
    out_cell_d = out_cell_q;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q;
    mem_wdata  = {color_q, BLANK_CHAR};
    mem_re     = 1'b0;
    mem_raddr  = cnt_q;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    // copy half of a scroll: data read last cycle goes one row up
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = waddr_q;
      mem_wdata = mem_rdata;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = {RESET_COLOR, BLANK_CHAR};
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cell_d  = '0;
          state_d = ST_FINISH;
          case (cmd_i.operation)
            OP_WRITE: begin
              case (cmd_i.char_code)
                CH_LF: begin
                  col_d = '0;
                  if (row_last) begin
                    state_d = ST_SCROLL;
                    cnt_d   = ADDR_W'(COLUMNS);
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end
                CH_CR: col_d = '0;
                CH_BS: begin
                  if (col_q != '0) begin
                    col_d = col_q - 1'b1;
                  end
                end
                CH_TAB: ;
                default: begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_addr;
                  mem_wdata = {color_q, cmd_i.char_code};
                  if (col_last) begin
                    col_d = '0;
                    if (row_last) begin
                      state_d = ST_SCROLL;
                      cnt_d   = ADDR_W'(COLUMNS);
                    end else begin
                      row_d = row_q + 1'b1;
                    end
                  end else begin
                    col_d = col_q + 1'b1;
                  end
                end
              endcase
            end
            OP_MOVE: begin
              row_d = arg_row;
              col_d = arg_col;
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = arg_addr;
              state_d   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cell_d  = mem_rdata;
        state_d = ST_FINISH;
      end
      ST_SCROLL: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_q;
        pend_d    = 1'b1;
        waddr_d   = cnt_q - ADDR_W'(COLUMNS);
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = ADDR_W'((ROWS - 1) * COLUMNS);
          state_d = ST_FILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FILL: begin
        // wait for the last copy to free the write port
        if (!pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q;
          mem_wdata = {color_q, BLANK_CHAR};
          if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
            cnt_d   = '0;
            state_d = ST_FINISH;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d  = 1'b1;
          out_row_d  = OUT_ROW_W'(row_q);
          out_col_d  = OUT_COL_W'(col_q);
          out_pos_d  = OUT_POS_W'(cur_pos);
          out_cell_d = cell_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      color_q   <= RESET_COLOR;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      row_q     <= row_d;
      col_q     <= col_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q    <= waddr_d;
    cell_q     <= cell_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_pos_q  <= out_pos_d;
    out_cell_q <= out_cell_d;
  end

  ttw_cell_ram #(
    .Depth(CELL_COUNT),
    .Width(CELL_W)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.cursor_row      = out_row_q;
  assign rsp_o.cursor_col      = out_col_q;
  assign rsp_o.cursor_position = out_pos_q;
  assign rsp_o.cell_data       = out_cell_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= ROW_W'(ROWS - 1)) && (col_q <= COL_W'(COLUMNS - 1)))
    else $error("cursor outside the screen");

  a_copy_only_in_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_SCROLL || state_q == ST_FILL))
    else $error("scroll copy pending outside a scroll");

  a_read_goes_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation == OP_READ) |=> (state_q == ST_READ))
    else $error("cell read did not wait for memory data");

  a_no_write_while_finishing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH || state_q == ST_READ) |-> !mem_we)
    else $error("screen write outside an update step");

endmodule

// ----- src/ttw_cell_ram.sv -----
module ttw_cell_ram import ttw_pkg::*; #(
  parameter int Depth = CELL_COUNT,
  parameter int Width = CELL_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/tb_text_terminal_writer_core.sv -----
`timescale 1ns / 1ps

module tb_text_terminal_writer_core;
  import ttw_pkg::*;

  // operation code with no effect, not a member of op_e
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_POS_W-1:0] pos;
    logic [CELL_W-1:0]    data;
  } cursor_report_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;

  ttw_cmd_if cmd_if ();
  ttw_rsp_if rsp_if ();

  text_terminal_writer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the terminal
  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  int unsigned       shadow_row;
  int unsigned       shadow_col;
  logic [7:0]        shadow_color;

  cursor_report_t pending_reports [$];

  bit sender_idle_en = 1'b1;
  bit recv_idle_en   = 1'b1;
  bit cmd_driving    = 1'b0;

  int error_count  = 0;
  int report_count = 0;
  int write_count  = 0;
  int move_count   = 0;
  int read_count   = 0;
  int nop_count    = 0;
  int scroll_count = 0;
  int color_count  = 0;

  function automatic void step_down_row();
    if (shadow_row < ROWS - 1) begin
      shadow_row++;
    end else begin
      for (int k = 0; k < CELL_COUNT - COLUMNS; k++) begin
        shadow_screen[k] = shadow_screen[k + COLUMNS];
      end
      for (int k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++) begin
        shadow_screen[k] = {shadow_color, BLANK_CHAR};
      end
      scroll_count++;
    end
  endfunction

  function automatic void put_char(logic [7:0] ch);
    case (ch)
      CH_LF: begin
        shadow_col = 0;
        step_down_row();
      end
      CH_CR: begin
        shadow_col = 0;
      end
      CH_BS: begin
        if (shadow_col > 0) shadow_col--;
      end
      CH_TAB: ;
      default: begin
        shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_color, ch};
        shadow_col++;
        if (shadow_col >= COLUMNS) begin
          shadow_col = 0;
          step_down_row();
        end
      end
    endcase
  endfunction

  function automatic cursor_report_t next_cursor_report(logic [1:0] op, logic [7:0] ch,
                                                        logic [7:0] row, logic [7:0] col);
    int unsigned    r;
    int unsigned    k;
    cursor_report_t rep;
    r = (row > ROWS - 1) ? ROWS - 1 : row;
    k = (col > COLUMNS - 1) ? COLUMNS - 1 : col;
    rep.data = '0;
    case (op)
      OP_WRITE: put_char(ch);
      OP_MOVE: begin
        shadow_row = r;
        shadow_col = k;
      end
      OP_READ: rep.data = shadow_screen[r * COLUMNS + k];
      default: ;
    endcase
    rep.row = OUT_ROW_W'(shadow_row);
    rep.col = OUT_COL_W'(shadow_col);
    rep.pos = OUT_POS_W'(shadow_row * COLUMNS + shadow_col);
    return rep;
  endfunction

  // sink side stalls
  always @(posedge clk_i) begin
    rsp_if.ready <= !(recv_idle_en && $urandom_range(99) < 29);
  end

  always @(posedge clk_i) begin : check_reports
    cursor_report_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      report_count++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d pos %0d cell %h", $time,
                 rsp_if.cursor_row, rsp_if.cursor_col, rsp_if.cursor_position,
                 rsp_if.cell_data);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (rsp_if.cursor_row !== want.row) begin
          $display("%0t: cursor_row expected %0d actual %0d", $time, want.row,
                   rsp_if.cursor_row);
          error_count++;
        end
        if (rsp_if.cursor_col !== want.col) begin
          $display("%0t: cursor_col expected %0d actual %0d", $time, want.col,
                   rsp_if.cursor_col);
          error_count++;
        end
        if (rsp_if.cursor_position !== want.pos) begin
          $display("%0t: cursor_position expected %0d actual %0d", $time, want.pos,
                   rsp_if.cursor_position);
          error_count++;
        end
        if (rsp_if.cell_data !== want.data) begin
          $display("%0t: cell_data expected %h actual %h", $time, want.data,
                   rsp_if.cell_data);
          error_count++;
        end
      end
    end
  end

  // called at a rising edge; returns at the edge of the transfer with valid still high
  task automatic send_cmd(logic [1:0] op, logic [7:0] ch, logic [7:0] row, logic [7:0] col);
    if (sender_idle_en && $urandom_range(99) < 29) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.char_code <= ch;
    cmd_if.row_arg   <= row;
    cmd_if.col_arg   <= col;
    cmd_driving = 1'b1;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_reports.push_back(next_cursor_report(op, ch, row, col));
    case (op)
      OP_WRITE: write_count++;
      OP_MOVE:  move_count++;
      OP_READ:  read_count++;
      default:  nop_count++;
    endcase
  endtask

  task automatic wait_results_done();
    if (cmd_driving) begin
      cmd_if.valid <= 1'b0;
      cmd_driving = 1'b0;
    end
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // only called with nothing in flight
  task automatic write_color(logic [7:0] color);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(posedge clk_i);
    shadow_color = color;
    cfg_we_i    <= 1'b0;
    color_count++;
  endtask

  task automatic test_controls_and_clamps();
    send_cmd(OP_READ, 8'h00, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'hFF, 8'd255, 8'd255);
    send_cmd(OP_NOP, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_WRITE, 8'hFF, 8'h00, 8'h00);
    send_cmd(OP_WRITE, 8'h00, 8'hFF, 8'hFF);
    send_cmd(OP_WRITE, CH_TAB, 8'd0, 8'd0);
    send_cmd(OP_WRITE, CH_BS, 8'd0, 8'd0);
    send_cmd(OP_WRITE, CH_BS, 8'd0, 8'd0);
    // backspace at column zero stays put
    send_cmd(OP_WRITE, CH_BS, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'd0, 8'd1);
    send_cmd(OP_MOVE, 8'h00, 8'd255, 8'd255);
    // wrap on the bottom-right cell scrolls
    send_cmd(OP_WRITE, "Z", 8'd0, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'd23, 8'd79);
    send_cmd(OP_READ, 8'h00, 8'd24, 8'd79);
    send_cmd(OP_READ, 8'h00, 8'd0, 8'd0);
    send_cmd(OP_WRITE, "q", 8'd0, 8'd0);
    send_cmd(OP_WRITE, CH_CR, 8'd0, 8'd0);
    send_cmd(OP_WRITE, CH_LF, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'd23, 8'd0);
    send_cmd(OP_MOVE, 8'h00, 8'd3, 8'd200);
    send_cmd(OP_WRITE, CH_LF, 8'd0, 8'd0);
    send_cmd(OP_MOVE, 8'h00, 8'd0, 8'd0);
    send_cmd(OP_WRITE, 8'h7F, 8'd0, 8'd0);
    wait_results_done();
  endtask

  task automatic test_text_colors();
    write_color(8'h00);
    send_cmd(OP_WRITE, "a", 8'd0, 8'd0);
    send_cmd(OP_MOVE, 8'h00, 8'd24, 8'd79);
    send_cmd(OP_WRITE, "b", 8'd0, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'd24, 8'd5);
    send_cmd(OP_READ, 8'h00, 8'd23, 8'd79);
    wait_results_done();
    // stored cells keep the color they were written with
    write_color(8'hFF);
    send_cmd(OP_READ, 8'h00, 8'd23, 8'd79);
    send_cmd(OP_WRITE, CH_LF, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'd24, 8'd0);
    send_cmd(OP_WRITE, "c", 8'd0, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'd24, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'd22, 8'd0);
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    logic [7:0] phase_colors [6];
    logic [1:0] op;
    logic [7:0] ch;
    logic [7:0] row;
    logic [7:0] col;
    int         pick;
    int         sel;
    phase_colors = '{8'h1F, RESET_COLOR, 8'h00, 8'($urandom), 8'hFF, 8'($urandom)};
    for (int phase = 0; phase < 6; phase++) begin
      write_color(phase_colors[phase]);
      // one phase runs flat out on both sides
      sender_idle_en = (phase != 3);
      recv_idle_en   = (phase != 3);
      for (int i = 0; i < 145; i++) begin
        if (phase == 1 && i == 70) wait_results_done();
        pick = $urandom_range(99);
        ch   = 8'($urandom);
        row  = 8'($urandom);
        col  = 8'($urandom);
        if (pick < 62) begin
          op  = OP_WRITE;
          sel = $urandom_range(99);
          if (sel < 72)      ch = 8'($urandom_range(8'h21, 8'h7E));
          else if (sel < 80) ch = CH_LF;
          else if (sel < 84) ch = CH_CR;
          else if (sel < 88) ch = CH_BS;
          else if (sel < 90) ch = CH_TAB;
        end else if (pick < 74) begin
          op = OP_MOVE;
          if ($urandom_range(3) != 0) begin
            row = $urandom_range(1) ? 8'($urandom_range(ROWS - 3, ROWS - 1))
                                    : 8'($urandom_range(ROWS - 1));
            col = $urandom_range(1) ? 8'($urandom_range(COLUMNS - 8, COLUMNS - 1))
                                    : 8'($urandom_range(COLUMNS - 1));
          end
        end else if (pick < 95) begin
          op = OP_READ;
          // mostly near the cursor, where recent text lives
          if ($urandom_range(4) != 0) begin
            row = 8'($urandom_range(shadow_row, (shadow_row >= 3) ? shadow_row - 3 : 0));
            col = 8'($urandom_range(COLUMNS - 1));
          end
        end else begin
          op = OP_NOP;
        end
        send_cmd(op, ch, row, col);
      end
      wait_results_done();
    end
    sender_idle_en = 1'b1;
    recv_idle_en   = 1'b1;
  endtask

  initial begin
    cmd_if.valid     = 1'b0;
    cmd_if.operation = OP_WRITE;
    cmd_if.char_code = 8'h00;
    cmd_if.row_arg   = 8'h00;
    cmd_if.col_arg   = 8'h00;
    rsp_if.ready     = 1'b0;
    for (int k = 0; k < CELL_COUNT; k++) shadow_screen[k] = {RESET_COLOR, BLANK_CHAR};
    shadow_row   = 0;
    shadow_col   = 0;
    shadow_color = RESET_COLOR;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_controls_and_clamps();
    test_text_colors();
    test_random_traffic();

    wait_results_done();
    repeat (20) @(posedge clk_i);
    $display("covered %0d writes with %0d scrolls, %0d moves, %0d reads, %0d no-ops",
             write_count, scroll_count, move_count, read_count, nop_count);
    $display("%0d results checked across %0d color settings", report_count, color_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("timeout with %0d results outstanding", pending_reports.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ttw_pkg.sv
src/ttw_if.sv
src/ttw_cell_ram.sv
src/text_terminal_writer_core.sv
sim/tb_text_terminal_writer_core.sv
